@@ design/pls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and sizing constants for the packed load/store unit.
// ----------------------------------------------------------------------------
package pls_pkg;

   // Memory size in bytes (power of two, 16 .. 65536).
   localparam int MEM_BYTES = 65536;
   localparam int BANKS     = 8;
   localparam int BANK_W    = $clog2(BANKS);
   localparam int ROWS      = MEM_BYTES / BANKS;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   // Width of the row sum before wrap: holds a 13-bit row base plus a carry.
   localparam int ROW_SUM_W = ((ROW_W > 13) ? ROW_W : 13) + 1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_STORE = 1'b1;

   // Value types carried in the access hint; the last two are float types.
   localparam logic [1:0] TYPE_I32 = 2'd0;
   localparam logic [1:0] TYPE_I64 = 2'd1;
   localparam logic [1:0] TYPE_F32 = 2'd2;
   localparam logic [1:0] TYPE_F64 = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [15:0] address;
      logic [63:0] store_value;
      logic [5:0]  hint;
   } req_type;

   typedef struct packed {
      logic [63:0] load_value;
      logic        access_error;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/packed_load_store_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_load_store_unit
// Byte-addressed little-endian memory with packed, sign-extending accesses.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive req_payload and raise start; the transaction is
//    taken at a rising edge where start is high and busy is low. One load or
//    store per transaction.
//  - Response channel: every transaction yields one response, shown on
//    rsp_payload for exactly one cycle with rsp_strobe high. The receiver
//    cannot stall; it must take the response in that cycle.
//  - Response path: the accepting edge registers the bank reads and the
//    decoded request; the response is then built and registered in rsp_ff.
//    A new transaction can be taken every cycle while busy is low; each one
//    reads or writes the eight byte banks once at its own accepting edge, so
//    later transactions always see earlier stores and no forwarding is needed.
//  - Storage is eight byte-wide banks of MEM_BYTES/8 rows; the bank of byte
//    (address + i) is its low three bits, and accesses that cross a row use
//    the next row in the lower banks. Addresses wrap at MEM_BYTES.
//  - Reset starts a clearing pass that writes zero to one row of every bank
//    per cycle, through all MEM_BYTES/8 rows (8192 at 64 KiB). busy stays high
//    for the whole pass and no transaction is taken during it.
// ----------------------------------------------------------------------------
module packed_load_store_unit (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire pls_pkg::req_type req_payload,
   output logic                 rsp_strobe,
   output pls_pkg::rsp_type     rsp_payload
);

   // Control carried from the accepting edge to the cycle where read data
   // comes back from the banks.
   typedef struct packed {
      logic                          valid;
      logic                          kind;
      logic                          err;
      logic                          packed_acc;
      logic                          sign;
      logic                          type0;
      logic [3:0]                    nbytes;
      logic [pls_pkg::BANK_W-1:0]    lane;
   } stage_type;

   // Clearing pass state.
   logic                        clearing_ff, clearing_in;
   logic [pls_pkg::ROW_W-1:0]   clear_row_ff, clear_row_in;

   // Request decode.
   logic        accept;
   logic [1:0]  acc_ty;
   logic [2:0]  acc_width;
   logic        acc_err;
   logic [3:0]  acc_nbytes;
   logic [pls_pkg::BANK_W-1:0] acc_lane;

   stage_type   stage_ff, stage_in;

   // Bank ports.
   logic                      bank_we    [pls_pkg::BANKS];
   logic [pls_pkg::ROW_W-1:0] bank_addr  [pls_pkg::BANKS];
   logic [7:0]                bank_wdata [pls_pkg::BANKS];
   logic [7:0]                bank_rdata [pls_pkg::BANKS];

   // Response assembly.
   logic [63:0]       load_value;
   pls_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   assign busy   = clearing_ff;
   assign accept = start && !clearing_ff;
   assign acc_lane = req_payload.address[pls_pkg::BANK_W-1:0];

   // Decode the hint; the field layout differs between loads and stores.
   always_comb begin
      if (req_payload.kind == pls_pkg::KIND_STORE) begin
         acc_ty    = req_payload.hint[4:3];
         acc_width = req_payload.hint[2:0];
      end else begin
         acc_ty    = req_payload.hint[5:4];
         acc_width = req_payload.hint[3:1];
      end
      // Packing a float type, or packing type 0 to its full four bytes.
      acc_err = (acc_width != 3'd0) &&
                ((acc_ty == pls_pkg::TYPE_F32) || (acc_ty == pls_pkg::TYPE_F64) ||
                 ((acc_ty == pls_pkg::TYPE_I32) && (acc_width == 3'd4)));
      if (acc_width == 3'd0) begin
         acc_nbytes = ((acc_ty == pls_pkg::TYPE_I64) || (acc_ty == pls_pkg::TYPE_F64)) ?
                      4'd8 : 4'd4;
      end else begin
         acc_nbytes = {1'b0, acc_width};
      end
   end

   // Drive the banks: the clearing pass owns them, else the request does.
   always_comb begin
      for (int b = 0; b < pls_pkg::BANKS; b++) begin
         logic [pls_pkg::BANK_W-1:0] pos;
         logic [pls_pkg::ROW_SUM_W-1:0] row_sum;
         pos     = pls_pkg::BANK_W'(b) - acc_lane;
         // Banks below the start lane hold bytes of the following row.
         row_sum = pls_pkg::ROW_SUM_W'(req_payload.address[15:pls_pkg::BANK_W]) +
                   pls_pkg::ROW_SUM_W'(pls_pkg::BANK_W'(b) < acc_lane);
         if (clearing_ff) begin
            bank_we[b]    = 1'b1;
            bank_addr[b]  = clear_row_ff;
            bank_wdata[b] = 8'd0;
         end else begin
            bank_we[b]    = accept && (req_payload.kind == pls_pkg::KIND_STORE) &&
                            !acc_err && ({1'b0, pos} < acc_nbytes);
            bank_addr[b]  = row_sum[pls_pkg::ROW_W-1:0];
            bank_wdata[b] = req_payload.store_value[8*pos +: 8];
         end
      end
   end

   for (genvar g = 0; g < pls_pkg::BANKS; g++) begin : g_bank
      pls_ram #(
         .WIDTH (8),
         .DEPTH (pls_pkg::ROWS)
      ) u_bank (
         .clock (clock),
         .we    (bank_we[g]),
         .addr  (bank_addr[g]),
         .wdata (bank_wdata[g]),
         .rdata (bank_rdata[g])
      );
   end

   // Advance the clearing pass one row a cycle until the last row is done.
   always_comb begin
      clearing_in  = clearing_ff;
      clear_row_in = clear_row_ff;
      if (clearing_ff) begin
         clear_row_in = clear_row_ff + 1'b1;
         if (clear_row_ff == pls_pkg::ROW_W'(pls_pkg::ROWS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Capture the decoded transaction alongside the bank read.
   always_comb begin
      stage_in.valid      = accept;
      stage_in.kind       = req_payload.kind;
      stage_in.err        = acc_err;
      stage_in.packed_acc = (acc_width != 3'd0);
      stage_in.sign       = req_payload.hint[0];
      stage_in.type0      = (acc_ty == pls_pkg::TYPE_I32);
      stage_in.nbytes     = acc_nbytes;
      stage_in.lane       = acc_lane;
   end

   // Rotate bank data into byte order, then extend and mask.
   always_comb begin
      logic [7:0] raw [8];
      logic       ext;
      for (int i = 0; i < 8; i++) begin
         raw[i] = bank_rdata[pls_pkg::BANK_W'(i) + stage_ff.lane];
      end
      ext = stage_ff.packed_acc && stage_ff.sign &&
            raw[3'(stage_ff.nbytes - 4'd1)][7];
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < stage_ff.nbytes) begin
            load_value[8*i +: 8] = raw[i];
         end else begin
            load_value[8*i +: 8] = ext ? 8'hff : 8'h00;
         end
      end
      if (stage_ff.packed_acc && stage_ff.type0) begin
         load_value[63:32] = 32'd0;
      end
      // Stores and failed accesses return zero.
      if (stage_ff.err || (stage_ff.kind == pls_pkg::KIND_STORE)) begin
         load_value = 64'd0;
      end
   end

   always_comb begin
      rsp_in.load_value   = load_value;
      rsp_in.access_error = stage_ff.err;
      rsp_strobe_in       = stage_ff.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff    <= 1'b1;
         clear_row_ff   <= '0;
         stage_ff.valid <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         clearing_ff    <= clearing_in;
         clear_row_ff   <= clear_row_in;
         stage_ff.valid <= stage_in.valid;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      stage_ff.kind       <= stage_in.kind;
      stage_ff.err        <= stage_in.err;
      stage_ff.packed_acc <= stage_in.packed_acc;
      stage_ff.sign       <= stage_in.sign;
      stage_ff.type0      <= stage_in.type0;
      stage_ff.nbytes     <= stage_in.nbytes;
      stage_ff.lane       <= stage_in.lane;
      rsp_ff              <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ design/pls_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module pls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ design/pls_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_checker
// Port-level timing checks for the packed load/store unit.
// ----------------------------------------------------------------------------
module pls_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_strobe,
   input wire pls_pkg::rsp_type rsp_payload
);

   // Reset always launches the clearing pass.
   a_reset_busy : assert property (@(posedge clock) reset |=> busy)
      else $error("busy not raised after reset");

   // Every accepted transaction gets a response.
   a_response : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("missing response");

   // No response without an earlier accepted transaction.
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without transaction");

   // A failed access returns zero.
   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.access_error) |-> (rsp_payload.load_value == 64'd0))
      else $error("error response with nonzero value");

endmodule

bind packed_load_store_unit pls_checker u_pls_checker (.*);

`default_nettype wire
